@@ rtl/fcte_pkg.sv @@
// Shared types, constants and telegram byte functions for the inverter telegram engine.
package fcte_pkg;

  localparam int FrameBytes = 16;
  localparam int BeatW      = $clog2(FrameBytes);
  localparam int QueueDepth = 2;

  localparam logic [7:0] StartByte  = 8'h02;
  localparam logic [7:0] LenByte    = 8'h0E;
  localparam logic [3:0] AkRead     = 4'h1;
  localparam logic [7:0] AddrOffset = 8'd128;

  localparam logic [1:0] ActStart   = 2'd0;
  localparam logic [1:0] ActRxByte  = 2'd1;
  localparam logic [1:0] ActTimeout = 2'd2;

  localparam logic [1:0] OutOk       = 2'd0;
  localparam logic [1:0] OutChecksum = 2'd1;
  localparam logic [1:0] OutHeader   = 2'd2;
  localparam logic [1:0] OutTimeout  = 2'd3;

  localparam logic KindTx     = 1'b0;
  localparam logic KindReport = 1'b1;

  localparam logic [BeatW-1:0] LastPos = BeatW'(FrameBytes - 1);

  typedef enum logic [1:0] {
    PhIdle,
    PhWait,
    PhCollect
  } fcte_phase_e;

  // one queue entry: a request to expand, or a finished report
  typedef struct packed {
    logic        is_report;
    logic [11:0] pnu;
    logic [7:0]  addr_b;
    logic [1:0]  outcome;
    logic [31:0] value;
    logic [15:0] status;
  } fcte_cmd_t;

  function automatic logic [7:0] fcte_addr_byte(input logic [4:0] addr);
    logic [4:0] a;
    a = (addr == 5'd0) ? 5'd1 : addr;
    return AddrOffset | {3'b000, a};
  endfunction

  // request byte at a position, BCC excluded
  function automatic logic [7:0] fcte_req_byte(input logic [BeatW-1:0] pos,
                                               input logic [7:0] addr_b,
                                               input logic [11:0] pnu);
    logic [7:0] b;
    case (pos)
      BeatW'(0): b = StartByte;
      BeatW'(1): b = LenByte;
      BeatW'(2): b = addr_b;
      BeatW'(3): b = {AkRead, pnu[11:8]};
      BeatW'(4): b = pnu[7:0];
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/fc_inverter_telegram_engine_top.sv @@
// Path: an accepted input beat is registered in the command queue, and the back end then
//   registers its first result beat in the output register, where the master side takes it.
// Throughput: one input beat per cycle while the command queue has room; a start request
//   is expanded into sixteen transmit beats, one request byte per beat, as the output accepts them.
// Reports take one output beat; the command queue lets input flow while a beat waits, until it fills.
// Reset: asynchronous, active low; clears phase, counters, queue and output valid, and
//   sets the unit address to 1.
module fc_inverter_telegram_engine_top import fcte_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,     // unit_address
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // param_number[11:0], rx_byte[19:12], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // tx_byte[7:0], outcome[9:8], param_value[41:10],
                                       // status[57:42], zero fill
  output logic [0:0]  m_axis_tuser_o,  // kind
  output logic        m_axis_tlast_o   // last_byte
);

  logic      accept;
  logic      push, pop, full, head_valid;
  fcte_cmd_t cmd, head;

  logic        kind;
  logic [7:0]  tx_byte;
  logic [1:0]  outcome;
  logic [31:0] param_value;
  logic [15:0] pcd_status;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  fcte_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .action_i       (s_axis_tuser_i),
    .param_number_i (s_axis_tdata_i[11:0]),
    .rx_byte_i      (s_axis_tdata_i[19:12]),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  fcte_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head)
  );

  fcte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .kind_o        (kind),
    .tx_byte_o     (tx_byte),
    .last_byte_o   (m_axis_tlast_o),
    .outcome_o     (outcome),
    .param_value_o (param_value),
    .pcd_status_o  (pcd_status)
  );

  assign m_axis_tuser_o = kind;
  assign m_axis_tdata_o = {6'b0, pcd_status, param_value, outcome, tx_byte};

endmodule

@@ rtl/fcte_front.sv @@
// Front end: accepts beats, tracks the reply frame and queues requests and reports.
module fcte_front import fcte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        accept_i,
  input  logic [1:0]  action_i,
  input  logic [11:0] param_number_i,
  input  logic [7:0]  rx_byte_i,
  output logic        push_o,
  output fcte_cmd_t   cmd_o
);

  fcte_phase_e      phase_q, phase_d;
  logic [4:0]       unit_address_q;
  logic [BeatW-1:0] cnt_q, cnt_d;
  logic [7:0]       xor_q, xor_d;
  logic             hdr_q, hdr_d;
  logic [11:0]      pnu_q, pnu_d;
  logic [31:0]      value_q, value_d;
  logic [15:0]      status_q, status_d;

  logic [BeatW-1:0] pos;
  logic [7:0]       xor_cur;
  logic             hdr_cur;
  logic             frame_byte;
  logic             checked;
  logic [7:0]       expected;
  logic [7:0]       addr_b;

  assign addr_b = fcte_addr_byte(unit_address_q);

  // a start byte seen while waiting opens the frame at position zero
  assign pos     = (phase_q == PhWait) ? '0 : cnt_q;
  assign xor_cur = (phase_q == PhWait) ? 8'h00 : xor_q;
  assign hdr_cur = (phase_q == PhWait) ? 1'b1 : hdr_q;
  assign frame_byte = accept_i && (action_i == ActRxByte) &&
                      ((phase_q == PhCollect) ||
                       ((phase_q == PhWait) && (rx_byte_i == StartByte)));
  assign checked  = (pos <= BeatW'(2)) || ((pos >= BeatW'(4)) && (pos <= BeatW'(6)));
  assign expected = fcte_req_byte(pos, addr_b, pnu_q);

  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (phase_q)
        PhIdle: begin
          if (action_i == ActStart) phase_d = PhWait;
        end
        PhWait: begin
          if (frame_byte) phase_d = PhCollect;
          else if (action_i == ActTimeout) phase_d = PhIdle;
        end
        PhCollect: begin
          if (frame_byte && (pos == LastPos)) phase_d = PhIdle;
          else if (action_i == ActTimeout) phase_d = PhIdle;
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    hdr_d    = hdr_q;
    pnu_d    = pnu_q;
    value_d  = value_q;
    status_d = status_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    cmd_o.addr_b = addr_b;
    if (accept_i && (phase_q == PhIdle) && (action_i == ActStart)) begin
      pnu_d           = param_number_i;
      push_o          = 1'b1;
      cmd_o.is_report = 1'b0;
      cmd_o.pnu       = param_number_i;
    end
    if (frame_byte) begin
      if (pos != LastPos) begin
        cnt_d = pos + BeatW'(1);
        xor_d = xor_cur ^ rx_byte_i;
        hdr_d = hdr_cur & ~(checked && (rx_byte_i != expected));
        if ((pos >= BeatW'(7)) && (pos <= BeatW'(10))) value_d = {value_q[23:0], rx_byte_i};
        if ((pos == BeatW'(11)) || (pos == BeatW'(12))) status_d = {status_q[7:0], rx_byte_i};
      end else begin
        cnt_d           = '0;
        push_o          = 1'b1;
        cmd_o.is_report = 1'b1;
        if (rx_byte_i != xor_cur) begin
          cmd_o.outcome = OutChecksum;
        end else if (!hdr_cur) begin
          cmd_o.outcome = OutHeader;
        end else begin
          cmd_o.outcome = OutOk;
          cmd_o.value   = value_q;
          cmd_o.status  = status_q;
        end
      end
    end
    if (accept_i && (phase_q != PhIdle) && (action_i == ActTimeout)) begin
      cnt_d           = '0;
      push_o          = 1'b1;
      cmd_o.is_report = 1'b1;
      cmd_o.outcome   = OutTimeout;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      unit_address_q <= 5'd1;
      cnt_q          <= '0;
      xor_q          <= 8'h00;
      hdr_q          <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      hdr_q   <= hdr_d;
      if (cfg_we_i) unit_address_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pnu_q    <= pnu_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

endmodule

@@ rtl/fcte_queue.sv @@
// Short command queue between the front and back ends.
module fcte_queue import fcte_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fcte_cmd_t cmd_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output fcte_cmd_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fcte_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      if (do_push && !do_pop)      count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= cmd_i;
  end

endmodule

@@ rtl/fcte_back.sv @@
// Back end: expands requests into sixteen transmit beats and drives the output register.
module fcte_back import fcte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  fcte_cmd_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o,
  output logic [1:0]  outcome_o,
  output logic [31:0] param_value_o,
  output logic [15:0] pcd_status_o
);

  logic [BeatW-1:0] cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;
  logic             load;
  logic [7:0]       bcc;
  logic [7:0]       tx_d;

  logic        kind_q;
  logic [7:0]  tx_q;
  logic        last_q;
  logic [1:0]  outcome_q;
  logic [31:0] value_q;
  logic [15:0] status_q;

  always_comb begin
    bcc = 8'h00;
    for (int i = 0; i < FrameBytes - 1; i++) begin
      bcc = bcc ^ fcte_req_byte(BeatW'(i), head_i.addr_b, head_i.pnu);
    end
  end

  assign load  = head_valid_i && (!ovalid_q || out_ready_i);
  assign pop_o = load && (head_i.is_report || (cnt_q == LastPos));
  assign tx_d  = (cnt_q == LastPos) ? bcc : fcte_req_byte(cnt_q, head_i.addr_b, head_i.pnu);

  always_comb begin
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
      if (!head_i.is_report) cnt_d = (cnt_q == LastPos) ? '0 : cnt_q + BeatW'(1);
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.is_report) begin
        kind_q    <= KindReport;
        tx_q      <= 8'h00;
        last_q    <= 1'b0;
        outcome_q <= head_i.outcome;
        value_q   <= head_i.value;
        status_q  <= head_i.status;
      end else begin
        kind_q    <= KindTx;
        tx_q      <= tx_d;
        last_q    <= (cnt_q == LastPos);
        outcome_q <= OutOk;
        value_q   <= 32'h0;
        status_q  <= 16'h0;
      end
    end
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = kind_q;
  assign tx_byte_o     = tx_q;
  assign last_byte_o   = last_q;
  assign outcome_o     = outcome_q;
  assign param_value_o = value_q;
  assign pcd_status_o  = status_q;

endmodule

@@ rtl/fcte_checker.sv @@
// Port-level checker for the telegram engine, bound to the top level.
module fcte_checker import fcte_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  a_last_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[0] == KindTx)
    else $error("tlast on a report beat");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[0] == KindTx) |-> m_axis_tdata_o[63:8] == 56'h0)
    else $error("transmit beat carries report fields");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[0] == KindReport) && (m_axis_tdata_o[9:8] != OutOk)
      |-> (m_axis_tdata_o[57:10] == 48'h0) && (m_axis_tdata_o[7:0] == 8'h00))
    else $error("failed report carries value or status");

endmodule

bind fc_inverter_telegram_engine_top fcte_checker u_fcte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
